### rtl/aifg_pkg.sv
// aifg_pkg: shared constants for the arp inspection flood guard
// no dependencies
package aifg_pkg;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ARP_WELL_FORMED = 48'h0001_0800_0604;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_FLOOD  = 3'd0;
  localparam logic [2:0] REG_RATE   = 3'd1;
  localparam logic [2:0] REG_SRV    = 3'd2;
  localparam logic [2:0] REG_CLI    = 3'd3;
  localparam logic [2:0] REG_MIRLEN = 3'd4;

  localparam logic [3:0] RSN_OTHER = 4'd0;
  localparam logic [3:0] RSN_SHORT = 4'd1;
  localparam logic [3:0] RSN_DHCP  = 4'd2;
  localparam logic [3:0] RSN_ARPOK = 4'd3;
  localparam logic [3:0] RSN_FLOOD = 4'd4;
  localparam logic [3:0] RSN_SPOOF = 4'd5;
  localparam logic [3:0] RSN_GARP  = 4'd6;
  localparam logic [3:0] RSN_RATE  = 4'd7;
  localparam logic [3:0] RSN_BOUND = 4'd8;

endpackage

### rtl/arp_inspection_flood_guard_core.sv
// arp_inspection_flood_guard_core: top level of the arp inspection and flood guard
// depends on aifg_pkg, aifg_lru_chain, aifg_lru_cell, aifg_bind_cell
//
// one request is taken at a time. the cycle after it is accepted compares it
// against all three tables, the next cycle decides, updates the tables and loads
// the answer register, and the answer is offered from the cycle after that. a new
// request is taken only in the cycle after the answer has gone, so each request
// goes through compare, decide, answer and idle before the next one is taken;
// this is set by the compare-then-write pass through the rows of table cells.
// all three tables are rows of cells that compare against the broadcast key in
// parallel; lru order is kept by a per-entry rank that is zero for the newest
// entry and counts the entries used since.
module arp_inspection_flood_guard_core #(
  parameter int BINDING_ENTRIES   = 256,
  parameter int MAC_TRACK_ENTRIES = 1024,
  parameter int RATE_ENTRIES      = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [1:0]  in_header_depth,
  input  logic [13:0] in_frame_length,
  input  logic [47:0] in_source_mac,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic [15:0] in_udp_source_port,
  input  logic [15:0] in_udp_dest_port,
  input  logic [47:0] in_arp_format,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_target_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drop,
  output logic [3:0]  out_reason,
  output logic        out_mirror,
  output logic [11:0] out_mirror_length
);
  localparam int BIW = $clog2(BINDING_ENTRIES + 1);
  localparam int RIW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DEC, S_OUT} state_t;
  state_t state_r;

  // configuration registers
  logic [15:0] flood_thr_r, srv_port_r, cli_port_r;
  logic [7:0]  rate_lim_r;
  logic [11:0] mir_max_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flood_thr_r <= 16'd512;
      rate_lim_r  <= 8'd10;
      srv_port_r  <= 16'd67;
      cli_port_r  <= 16'd68;
      mir_max_r   <= 12'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        aifg_pkg::REG_FLOOD:  flood_thr_r <= cfg_data;
        aifg_pkg::REG_RATE:   rate_lim_r  <= cfg_data[7:0];
        aifg_pkg::REG_SRV:    srv_port_r  <= cfg_data;
        aifg_pkg::REG_CLI:    cli_port_r  <= cfg_data;
        aifg_pkg::REG_MIRLEN: mir_max_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic        cmd_r;
  logic [1:0]  dep_r;
  logic [13:0] flen_r;
  logic [47:0] smac_r, afmt_r, amac_r;
  logic [15:0] etype_r, sport_r, dport_r;
  logic [7:0]  proto_r;
  logic [31:0] sip_r, tip_r;

  wire take = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= in_command; dep_r <= in_header_depth; flen_r <= in_frame_length;
      smac_r <= in_source_mac; etype_r <= in_ether_type; proto_r <= in_ip_protocol;
      sport_r <= in_udp_source_port; dport_r <= in_udp_dest_port;
      afmt_r <= in_arp_format; amac_r <= in_sender_mac;
      sip_r <= in_sender_ip; tip_r <= in_target_ip;
    end
  end

  // ---- mac tracking row
  logic lookup;
  assign lookup = (state_r == S_LOOK);
  logic trk_hit, trk_commit;
  logic [$clog2(MAC_TRACK_ENTRIES+1)-1:0] trk_sel, trk_pick;
  aifg_lru_chain #(.N(MAC_TRACK_ENTRIES), .KW(48)) u_trk (
    .clk(clk), .rst_n(rst_n), .lookup(lookup), .key(smac_r),
    .commit(trk_commit), .hit(trk_hit), .sel(trk_sel), .pick(trk_pick)
  );

  // ---- rate row
  logic rl_hit, rl_commit;
  logic [$clog2(RATE_ENTRIES+1)-1:0] rl_sel, rl_pick;
  aifg_lru_chain #(.N(RATE_ENTRIES), .KW(32)) u_rl (
    .clk(clk), .rst_n(rst_n), .lookup(lookup), .key(sip_r),
    .commit(rl_commit), .hit(rl_hit), .sel(rl_sel), .pick(rl_pick)
  );
  logic [31:0] rl_cnt_r [RATE_ENTRIES];
  logic [31:0] rl_cur_r;
  // counter of the picked entry is read in the compare cycle, used in the decide cycle
  always_ff @(posedge clk) begin
    if (lookup) rl_cur_r <= rl_cnt_r[rl_pick[RIW-1:0]];
    if (rl_commit)
      rl_cnt_r[rl_sel[RIW-1:0]] <= rl_hit ?
        ((rl_cur_r == aifg_pkg::CNT_MAX) ? rl_cur_r : rl_cur_r + 32'd1) : 32'd1;
  end

  // ---- binding row
  logic [BINDING_ENTRIES-1:0] b_ok, b_hit, b_eq, b_wr;
  for (genvar g = 0; g < BINDING_ENTRIES; g++) begin : g_bind
    aifg_bind_cell u_b (
      .clk(clk), .rst_n(rst_n), .ip(sip_r), .mac(amac_r), .wr(b_wr[g]),
      .ok(b_ok[g]), .hit(b_hit[g]), .mac_eq(b_eq[g])
    );
  end
  logic           bhit_r, beq_r, bslot_ok_r;
  logic [BIW-1:0] bslot_r;
  always_ff @(posedge clk) begin
    if (lookup) begin
      logic [BIW-1:0] s;
      logic ok, h, e;
      s = '0; ok = 1'b0; h = 1'b0; e = 1'b0;
      for (int i = BINDING_ENTRIES - 1; i >= 0; i--)
        if (!b_ok[i]) begin s = BIW'(i); ok = 1'b1; end
      for (int i = BINDING_ENTRIES - 1; i >= 0; i--)
        if (b_hit[i]) begin s = BIW'(i); ok = 1'b1; h = 1'b1; e = b_eq[i]; end
      bslot_r <= s; bslot_ok_r <= ok; bhit_r <= h; beq_r <= e;
    end
  end
  for (genvar g = 0; g < BINDING_ENTRIES; g++) begin : g_bwr
    assign b_wr[g] = (state_r == S_DEC) && cmd_r && bslot_ok_r && bslot_r == BIW'(g);
  end

  // ---- decision
  logic [31:0] uniq_r, uniq_inc;
  logic        track, is_ipv4, is_arp, dhcp, arp_path;
  logic        drop_nxt, mir_nxt;
  logic [3:0]  rsn_nxt;
  logic [11:0] len_nxt;
  assign track    = !cmd_r && dep_r != 2'd0 && smac_r != aifg_pkg::MAC_BCAST && smac_r != '0;
  assign uniq_inc = (uniq_r == aifg_pkg::CNT_MAX) ? uniq_r : uniq_r + 32'd1;
  assign is_ipv4  = etype_r == aifg_pkg::ETYPE_IPV4;
  assign is_arp   = etype_r == aifg_pkg::ETYPE_ARP;
  assign dhcp     = sport_r == srv_port_r || sport_r == cli_port_r ||
                    dport_r == srv_port_r || dport_r == cli_port_r;
  logic flood;
  assign flood    = track && !trk_hit && uniq_inc > {16'd0, flood_thr_r};
  assign arp_path = !cmd_r && dep_r != 2'd0 && !flood && is_arp && dep_r == 2'd3 &&
                    afmt_r == aifg_pkg::ARP_WELL_FORMED && !bhit_r && sip_r != tip_r;
  assign trk_commit = (state_r == S_DEC) && track;
  assign rl_commit  = (state_r == S_DEC) && arp_path;

  always_comb begin
    drop_nxt = 1'b0; rsn_nxt = aifg_pkg::RSN_OTHER; mir_nxt = 1'b0; len_nxt = '0;
    if (cmd_r) rsn_nxt = aifg_pkg::RSN_BOUND;
    else if (dep_r == 2'd0) rsn_nxt = aifg_pkg::RSN_SHORT;
    else if (flood) begin drop_nxt = 1'b1; rsn_nxt = aifg_pkg::RSN_FLOOD; end
    else if (is_ipv4) begin
      if (dep_r < 2'd2) rsn_nxt = aifg_pkg::RSN_SHORT;
      else if (proto_r != aifg_pkg::PROTO_UDP) rsn_nxt = aifg_pkg::RSN_OTHER;
      else if (dep_r < 2'd3) rsn_nxt = aifg_pkg::RSN_SHORT;
      else if (dhcp) begin
        rsn_nxt = aifg_pkg::RSN_DHCP; mir_nxt = 1'b1;
        len_nxt = (flen_r > {2'b0, mir_max_r}) ? mir_max_r : flen_r[11:0];
      end
    end else if (is_arp) begin
      if (dep_r < 2'd3) rsn_nxt = aifg_pkg::RSN_SHORT;
      else if (afmt_r != aifg_pkg::ARP_WELL_FORMED) rsn_nxt = aifg_pkg::RSN_OTHER;
      else if (bhit_r) begin
        drop_nxt = !beq_r;
        rsn_nxt = beq_r ? aifg_pkg::RSN_ARPOK : aifg_pkg::RSN_SPOOF;
      end else if (sip_r == tip_r) begin
        drop_nxt = 1'b1; rsn_nxt = aifg_pkg::RSN_GARP;
      end else if (rl_hit && ((rl_cur_r == aifg_pkg::CNT_MAX) ? rl_cur_r : rl_cur_r + 32'd1)
                   > {24'd0, rate_lim_r}) begin
        drop_nxt = 1'b1; rsn_nxt = aifg_pkg::RSN_RATE;
      end else rsn_nxt = aifg_pkg::RSN_ARPOK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uniq_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (take) state_r <= S_LOOK;
        S_LOOK: state_r <= S_DEC;
        S_DEC: begin
          if (track && !trk_hit) uniq_r <= uniq_inc;
          out_drop <= drop_nxt; out_reason <= rsn_nxt;
          out_mirror <= mir_nxt; out_mirror_length <= len_nxt;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
  assign out_valid = (state_r == S_OUT);

  // answer shows only in its own state, and no new request while it waits
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while answer waits");
  a_mirror_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mirror |-> out_mirror_length == '0) else $error("stray mirror length");
  a_drop_rsn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop |-> out_reason == aifg_pkg::RSN_FLOOD ||
      out_reason == aifg_pkg::RSN_SPOOF || out_reason == aifg_pkg::RSN_GARP ||
      out_reason == aifg_pkg::RSN_RATE) else $error("drop with pass reason");
endmodule

### rtl/aifg_lru_cell.sv
// aifg_lru_cell: one entry of an lru table with a use rank
// depends on nothing
module aifg_lru_cell #(
  parameter int KW = 48,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          lookup,      // compare phase strobe
  input  logic [KW-1:0] key,
  input  logic          touch,       // refresh / insert this entry
  input  logic          age,         // an lru access happened
  input  logic [AW-1:0] lim,         // rank of the entry being used
  output logic          hit,
  output logic          ok,
  output logic [AW-1:0] age_o
);
  logic          ok_r;
  logic [KW-1:0] key_r;
  logic [AW-1:0] age_r;

  assign hit   = lookup & ok_r & (key_r == key);
  assign ok    = ok_r;
  assign age_o = age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r  <= 1'b0;
      age_r <= '0;
    end else if (touch) begin
      ok_r  <= 1'b1;
      key_r <= key;
      age_r <= '0;
    end else if (age && ok_r && age_r < lim) begin
      age_r <= age_r + 1'b1;
    end
  end
endmodule

### rtl/aifg_lru_chain.sv
// aifg_lru_chain: row of lru cells with priority select for hit, free and oldest entry
// depends on aifg_lru_cell
module aifg_lru_chain #(
  parameter int N  = 256,
  parameter int KW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          lookup,
  input  logic [KW-1:0] key,
  input  logic          commit,      // write phase: refresh hit or insert victim
  output logic          hit,
  output logic [$clog2(N+1)-1:0] sel, // hit index or victim index
  output logic [$clog2(N+1)-1:0] pick // same choice, during the compare cycle
);
  localparam int AW = $clog2(N + 1) + 1;
  localparam int IW = $clog2(N + 1);
  logic [N-1:0]  hits, oks, touch;
  logic [AW-1:0] ages [N];
  logic [IW-1:0] sel_r;
  logic [AW-1:0] sel_age_r;
  logic          hit_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    aifg_lru_cell #(.KW(KW), .AW(AW)) u_cell (
      .clk(clk), .rst_n(rst_n), .lookup(lookup), .key(key),
      .touch(touch[g]), .age(commit), .lim(sel_age_r), .hit(hits[g]), .ok(oks[g]),
      .age_o(ages[g])
    );
    assign touch[g] = commit && (sel_r == IW'(g));
  end

  // ranks of valid entries are always 0..k-1; the full table's oldest has rank N-1
  // priority choice: hit, else lowest free, else oldest
  logic [IW-1:0] pick_c;
  logic [AW-1:0] pick_age;
  logic          any_hit;
  always_comb begin
    logic          found_free;
    logic [IW-1:0] old_i;
    pick_c = '0; pick_age = '1; any_hit = 1'b0; found_free = 1'b0; old_i = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (ages[i] == AW'(N - 1)) old_i = IW'(i);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (!oks[i]) begin
        found_free = 1'b1;
        pick_c = IW'(i);
      end
    end
    if (!found_free) begin
      pick_c = old_i;
      pick_age = AW'(N - 1);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (hits[i]) begin
        any_hit = 1'b1;
        pick_c = IW'(i);
        pick_age = ages[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      sel_r     <= pick_c;
      sel_age_r <= pick_age;
      hit_r     <= any_hit;
    end
  end
  assign hit  = hit_r;
  assign sel  = sel_r;
  assign pick = pick_c;
endmodule

### rtl/aifg_bind_cell.sv
// aifg_bind_cell: one ip to mac binding entry
// depends on nothing
module aifg_bind_cell (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] ip,
  input  logic [47:0] mac,
  input  logic        wr,
  output logic        ok,
  output logic        hit,
  output logic        mac_eq
);
  logic        ok_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  assign ok     = ok_r;
  assign hit    = ok_r && ip_r == ip;
  assign mac_eq = mac_r == mac;
  always_ff @(posedge clk) begin
    if (!rst_n) ok_r <= 1'b0;
    else if (wr) begin
      ok_r  <= 1'b1;
      ip_r  <= ip;
      mac_r <= mac;
    end
  end
endmodule
